// ===== rtl/kf2_pkg.sv =====
`default_nettype none
package kf2_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W = 31;
  localparam int IDX_W = 2;
  localparam int DEFAULT_FRAC_BITS = 16;

  localparam logic [IDX_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE = 2'd1;
  localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;

  localparam logic [CFG_W-1:0] RST_TIME_STEP = 31'd655;
  localparam logic [CFG_W-1:0] RST_PROCESS_NOISE = 31'd164;
  localparam logic [CFG_W-1:0] RST_MEASURE_NOISE = 31'd6554;

  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_MULW,
    ST_DIVS,
    ST_DIVW,
    ST_DONE
  } state_t;

  typedef enum logic [5:0] {
    SP_U0  = 6'd0,
    SP_U1  = 6'd1,
    SP_U2  = 6'd2,
    SP_U3  = 6'd3,
    SP_U4  = 6'd4,
    SP_U5  = 6'd5,
    SP_U6  = 6'd6,
    SP_U7  = 6'd7,
    SP_U8  = 6'd8,
    SP_U9  = 6'd9,
    SP_U10 = 6'd10,
    SP_U11 = 6'd11,
    SP_U12 = 6'd12,
    SP_U13 = 6'd13,
    SP_U14 = 6'd14,
    SP_U15 = 6'd15,
    SP_U16 = 6'd16,
    SP_U17 = 6'd17,
    SP_U18 = 6'd18,
    SP_U19 = 6'd19,
    SP_U20 = 6'd20,
    SP_U21 = 6'd21,
    SP_U22 = 6'd22,
    SP_U23 = 6'd23,
    SP_U24 = 6'd24,
    SP_U25 = 6'd25,
    SP_P0  = 6'd32,
    SP_P1  = 6'd33,
    SP_P2  = 6'd34,
    SP_P3  = 6'd35
  } step_t;

  function automatic logic signed [DATA_W-1:0] sat36(input logic signed [35:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 36'sh07FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sh080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [35:0] sx(input logic signed [DATA_W-1:0] v);
    return {{4{v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [DATA_W-1:0] sadd(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
    return sat36(sx(a) + sx(b));
  endfunction

  function automatic logic signed [DATA_W-1:0] ssub(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
    return sat36(sx(a) - sx(b));
  endfunction

  function automatic logic signed [DATA_W-1:0] sneg(input logic signed [DATA_W-1:0] a);
    return sat36(-sx(a));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/kf2_mul.sv =====
`default_nettype none
module kf2_mul #(
  parameter int FRAC_BITS = kf2_pkg::DEFAULT_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [kf2_pkg::DATA_W-1:0] a,
  input  wire logic signed [kf2_pkg::DATA_W-1:0] b,
  output logic                                   done,
  output logic signed [kf2_pkg::DATA_W-1:0]      result
);
  import kf2_pkg::*;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic run;
  logic fin;
  logic [4:0] cnt;
  logic signed [DATA_W:0] hi;
  logic [DATA_W-1:0] lo;
  logic signed [DATA_W:0] mcand;
  logic signed [DATA_W:0] addend;
  logic signed [DATA_W:0] sum;
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  logic signed [63:0] sh;
  logic signed [DATA_W-1:0] sat_res;

  always_comb begin
    if (!lo[0]) begin
      addend = '0;
    end else if (cnt == 5'd31) begin
      addend = -mcand;
    end else begin
      addend = mcand;
    end
    sum = hi + addend;
    prod = {hi[DATA_W-1:0], lo};
    rnd = prod + HALF;
    sh = rnd >>> FRAC_BITS;
    if (sh > 64'sh000000007FFFFFFF) begin
      sat_res = 32'sh7FFFFFFF;
    end else if (sh < -64'sh0000000080000000) begin
      sat_res = 32'sh80000000;
    end else begin
      sat_res = sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      fin <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi <= '0;
      lo <= b;
      mcand <= {a[DATA_W-1], a};
    end else if (run) begin
      hi <= {sum[DATA_W], sum[DATA_W:1]};
      lo <= {sum[0], lo[DATA_W-1:1]};
    end
    if (fin) begin
      result <= sat_res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kf2_div.sv =====
`default_nettype none
module kf2_div #(
  parameter int FRAC_BITS = kf2_pkg::DEFAULT_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [kf2_pkg::DATA_W-1:0] det,
  output logic                                   done,
  output logic signed [kf2_pkg::DATA_W-1:0]      result
);
  import kf2_pkg::*;

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QW);

  logic run;
  logic fin;
  logic [CW-1:0] cnt;
  logic neg;
  logic [DATA_W-1:0] dm;
  logic [DATA_W-1:0] rem;
  logic [QW-1:0] num;
  logic [QW-1:0] q;
  logic [DATA_W:0] trial;
  logic qbit;
  logic [DATA_W:0] rem_next;
  logic [63:0] qz;
  logic signed [DATA_W-1:0] sat_res;
  logic [DATA_W:0] det_ext;

  always_comb begin
    det_ext = {det[DATA_W-1], det};
    trial = {rem, num[QW-1]};
    qbit = (trial >= {1'b0, dm});
    rem_next = qbit ? (trial - {1'b0, dm}) : trial;
    qz = 64'(q);
    if (!neg) begin
      sat_res = (qz > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : qz[DATA_W-1:0];
    end else begin
      sat_res = (qz > 64'h80000000) ? 32'sh80000000 : -qz[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      fin <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(QW - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= det[DATA_W-1];
      dm <= det[DATA_W-1] ? DATA_W'(-det_ext) : det;
      rem <= '0;
      num <= QW'(1) << (2 * FRAC_BITS);
      q <= '0;
    end else if (run) begin
      rem <= rem_next[DATA_W-1:0];
      num <= {num[QW-2:0], 1'b0};
      q <= {q[QW-2:0], qbit};
    end
    if (fin) begin
      result <= sat_res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kalman_filter_two_state.sv =====
// Two-state angle and rate Kalman filter in signed fixed point, built around one bit-serial
// multiplier and one bit-serial divider that a step sequencer shares across the whole
// computation. Each multiply step holds the sequencer through an issue state, the serial shift
// and the rounding and hand-over of the product, and the division holds it in the same way.
// A predict word runs only multiplies, an update word runs its 26 multiplies and one division,
// and an update with a zero determinant ends after its first two multiplies; an output stall
// keeps the sequencer waiting in its done state until the result is delivered.
// A new word is taken once the previous one has finished, even while its result still waits
// at the output.
`default_nettype none
module kalman_filter_two_state #(
  parameter int FRAC_BITS = kf2_pkg::DEFAULT_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [kf2_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [kf2_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              kind,
  input  wire logic signed [kf2_pkg::DATA_W-1:0] sensed_angle,
  input  wire logic signed [kf2_pkg::DATA_W-1:0] meas_rate,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [kf2_pkg::DATA_W-1:0]      est_angle,
  output logic signed [kf2_pkg::DATA_W-1:0]      est_rate,
  output logic                                   update_skipped
);
  import kf2_pkg::*;

  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  state_t state;
  state_t state_next;
  step_t step;

  logic [CFG_W-1:0] time_step;
  logic [CFG_W-1:0] process_noise;
  logic [CFG_W-1:0] measure_noise;

  logic signed [DATA_W-1:0] angle_state;
  logic signed [DATA_W-1:0] rate_state;
  logic signed [DATA_W-1:0] p00;
  logic signed [DATA_W-1:0] p01;
  logic signed [DATA_W-1:0] p10;
  logic signed [DATA_W-1:0] p11;

  logic signed [DATA_W-1:0] y0;
  logic signed [DATA_W-1:0] y1;
  logic signed [DATA_W-1:0] s00;
  logic signed [DATA_W-1:0] s11;
  logic signed [DATA_W-1:0] t;
  logic signed [DATA_W-1:0] det;
  logic signed [DATA_W-1:0] inv;
  logic signed [DATA_W-1:0] i00;
  logic signed [DATA_W-1:0] i01;
  logic signed [DATA_W-1:0] i10;
  logic signed [DATA_W-1:0] i11;
  logic signed [DATA_W-1:0] k00;
  logic signed [DATA_W-1:0] k01;
  logic signed [DATA_W-1:0] k10;
  logic signed [DATA_W-1:0] k11;
  logic signed [DATA_W-1:0] n00;
  logic signed [DATA_W-1:0] n01;
  logic signed [DATA_W-1:0] n10;
  logic skip;
  logic kind_q;

  logic signed [DATA_W-1:0] op_a;
  logic signed [DATA_W-1:0] op_b;
  logic mul_start;
  logic mul_done;
  logic signed [DATA_W-1:0] mul_res;
  logic div_start;
  logic div_done;
  logic signed [DATA_W-1:0] div_res;
  logic signed [DATA_W-1:0] dt32;
  logic signed [DATA_W-1:0] q32;
  logic signed [DATA_W-1:0] r32;
  logic signed [DATA_W-1:0] det_c;
  logic signed [DATA_W-1:0] pair;
  logic signed [DATA_W-1:0] n00_c;
  logic last_step;
  logic accept;
  logic deliver;

  kf2_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(op_a), .b(op_b),
    .done(mul_done), .result(mul_res)
  );

  kf2_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .det(det),
    .done(div_done), .result(div_res)
  );

  always_comb begin
    dt32 = {1'b0, time_step};
    q32 = {1'b0, process_noise};
    r32 = {1'b0, measure_noise};
    det_c = ssub(t, mul_res);
    pair = sadd(t, mul_res);
    n00_c = sat36(sx(p00) + sx(t) + sx(t) + sx(mul_res) + sx(q32));
    last_step = (step == SP_U25) || (step == SP_P3);
    accept = in_valid && !in_stall;
    deliver = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_comb begin
    op_a = s00;
    op_b = s11;
    case (step)
      SP_U0: begin op_a = s00; op_b = s11; end
      SP_U1: begin op_a = p01; op_b = p10; end
      SP_U2: begin op_a = s11; op_b = inv; end
      SP_U3: begin op_a = sneg(p01); op_b = inv; end
      SP_U4: begin op_a = sneg(p10); op_b = inv; end
      SP_U5: begin op_a = s00; op_b = inv; end
      SP_U6: begin op_a = p00; op_b = i00; end
      SP_U7: begin op_a = p01; op_b = i10; end
      SP_U8: begin op_a = p00; op_b = i01; end
      SP_U9: begin op_a = p01; op_b = i11; end
      SP_U10: begin op_a = p10; op_b = i00; end
      SP_U11: begin op_a = p11; op_b = i10; end
      SP_U12: begin op_a = p10; op_b = i01; end
      SP_U13: begin op_a = p11; op_b = i11; end
      SP_U14: begin op_a = k00; op_b = y0; end
      SP_U15: begin op_a = k01; op_b = y1; end
      SP_U16: begin op_a = k10; op_b = y0; end
      SP_U17: begin op_a = k11; op_b = y1; end
      SP_U18: begin op_a = k00; op_b = p00; end
      SP_U19: begin op_a = k01; op_b = p10; end
      SP_U20: begin op_a = k00; op_b = p01; end
      SP_U21: begin op_a = k01; op_b = p11; end
      SP_U22: begin op_a = k10; op_b = p00; end
      SP_U23: begin op_a = k11; op_b = p10; end
      SP_U24: begin op_a = k10; op_b = p01; end
      SP_U25: begin op_a = k11; op_b = p11; end
      SP_P0: begin op_a = rate_state; op_b = dt32; end
      SP_P1: begin op_a = p01; op_b = dt32; end
      SP_P2: begin op_a = p11; op_b = dt32; end
      SP_P3: begin op_a = i00; op_b = dt32; end
      default: begin op_a = s00; op_b = s11; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: state_next = ST_MULW;
      ST_MULW: begin
        if (mul_done) begin
          if (last_step) begin
            state_next = ST_DONE;
          end else if (step == SP_U1) begin
            state_next = (det_c == '0) ? ST_DONE : ST_DIVS;
          end else begin
            state_next = ST_ISSUE;
          end
        end
      end
      ST_DIVS: state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_next = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (deliver) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    mul_start = (state == ST_ISSUE);
    div_start = (state == ST_DIVS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      time_step <= RST_TIME_STEP;
      process_noise <= RST_PROCESS_NOISE;
      measure_noise <= RST_MEASURE_NOISE;
      angle_state <= '0;
      rate_state <= '0;
      p00 <= ONE;
      p01 <= '0;
      p10 <= '0;
      p11 <= ONE;
      step <= SP_U0;
      skip <= 1'b0;
      kind_q <= KIND_PREDICT;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        case (cfg_index)
          REG_TIME_STEP: time_step <= cfg_data;
          REG_PROCESS_NOISE: process_noise <= cfg_data;
          REG_MEASURE_NOISE: measure_noise <= cfg_data;
          default: ;
        endcase
      end
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        kind_q <= kind;
        skip <= 1'b0;
        step <= (kind == KIND_UPDATE) ? SP_U0 : SP_P0;
      end
      if (state == ST_MULW && mul_done) begin
        if (!last_step && step != SP_U1) begin
          step <= step_t'(step + 6'd1);
        end
        case (step)
          SP_U1: begin
            if (det_c == '0) begin
              skip <= 1'b1;
            end
          end
          SP_U15: angle_state <= sadd(angle_state, pair);
          SP_U17: rate_state <= sadd(rate_state, pair);
          SP_U25: begin
            p00 <= n00;
            p01 <= n01;
            p10 <= n10;
            p11 <= ssub(p11, pair);
          end
          SP_P0: angle_state <= sadd(angle_state, mul_res);
          SP_P3: begin
            p00 <= n00_c;
            p01 <= sadd(p01, i00);
            p10 <= sadd(p01, i00);
            p11 <= sadd(p11, q32);
          end
          default: ;
        endcase
      end
      if (state == ST_DIVW && div_done) begin
        step <= SP_U2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y0 <= ssub(sensed_angle, angle_state);
      y1 <= ssub(meas_rate, rate_state);
      s00 <= sadd(p00, r32);
      s11 <= sadd(p11, r32);
    end
    if (state == ST_DIVW && div_done) begin
      inv <= div_res;
    end
    if (state == ST_MULW && mul_done) begin
      // The P01 * dt product must survive the P11 * dt step for the final P00 sum.
      if (step != SP_P2) begin
        t <= mul_res;
      end
      case (step)
        SP_U1: det <= det_c;
        SP_U2: i00 <= mul_res;
        SP_U3: i01 <= mul_res;
        SP_U4: i10 <= mul_res;
        SP_U5: i11 <= mul_res;
        SP_U7: k00 <= pair;
        SP_U9: k01 <= pair;
        SP_U11: k10 <= pair;
        SP_U13: k11 <= pair;
        SP_U19: n00 <= ssub(p00, pair);
        SP_U21: n01 <= ssub(p01, pair);
        SP_U23: n10 <= ssub(p10, pair);
        SP_P2: i00 <= mul_res;
        default: ;
      endcase
    end
    if (deliver) begin
      est_angle <= angle_state;
      est_rate <= rate_state;
      update_skipped <= skip;
    end
  end

  a_skip_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULW && mul_done && step == SP_U1 && det_c == '0)
      |=> (state == ST_DONE && skip))
    else $error("zero determinant did not end the update");

  a_pred_sym: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && kind_q == KIND_PREDICT) |-> (p01 == p10))
    else $error("covariance not symmetric after predict");

  a_mul_latency: assert property (@(posedge clk) disable iff (rst)
    mul_start |=> !mul_done)
    else $error("multiplier finished too early");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

endmodule
`default_nettype wire
